// ===== src/sacrr_pkg.sv =====
`default_nettype none
package sacrr_pkg;

  localparam int ADDR_W     = 32;
  localparam int OFF_W      = 2;
  localparam int WAYS       = 4;
  localparam int WAY_W      = 2;
  localparam int SETS       = 256;
  localparam int SET_W      = 8;
  localparam int TAG_W      = ADDR_W - OFF_W;
  localparam int IW_W       = 4;
  localparam int NW_W       = 3;
  localparam int CNT_W      = 32;
  localparam int META_W     = WAY_W + WAYS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int RES_W      = 2 + WAY_W + 2 * CNT_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - RES_W;

  localparam logic [CFG_IDX_W-1:0] REG_INDEX_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd1;

  localparam logic [IW_W-1:0] IW_RESET = 4'd8;
  localparam logic [IW_W-1:0] IW_MAX   = IW_W'(SET_W);
  localparam logic [NW_W-1:0] NW_RESET = 3'd4;
  localparam logic [NW_W-1:0] NW_MAX   = NW_W'(WAYS);

  typedef struct packed {
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] hit_total;
    logic [WAY_W-1:0] way_used;
    logic             filled_empty;
    logic             is_hit;
  } result_t;

endpackage
`default_nettype wire

// ===== src/sacrr_front.sv =====
`default_nettype none
module sacrr_front (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [sacrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [sacrr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [sacrr_pkg::ADDR_W-1:0]     in_tdata,
  input  wire                             q_full,
  input  wire                             clearing,
  output logic                            push,
  output sacrr_pkg::req_t                 push_req,
  output logic [sacrr_pkg::NW_W-1:0]      ways_eff
);
  import sacrr_pkg::*;

  logic [IW_W-1:0]  iw_r, iw_nxt;
  logic [NW_W-1:0]  nw_r, nw_nxt;
  logic [IW_W-1:0]  iw_eff;
  logic [SET_W-1:0] set_mask;

  assign cfg_ready = 1'b1;

  always_comb begin
    iw_nxt = iw_r;
    nw_nxt = nw_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_INDEX_WIDTH: iw_nxt = cfg_data[IW_W-1:0];
        REG_WAYS_IN_USE: nw_nxt = cfg_data[NW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= IW_RESET;
      nw_r <= NW_RESET;
    end else begin
      iw_r <= iw_nxt;
      nw_r <= nw_nxt;
    end
  end

  // saturate the register fields to what the arrays hold
  assign iw_eff = (iw_r > IW_MAX) ? IW_MAX : iw_r;

  always_comb begin
    if (nw_r == '0) begin
      ways_eff = NW_W'(1);
    end else if (nw_r > NW_MAX) begin
      ways_eff = NW_MAX;
    end else begin
      ways_eff = nw_r;
    end
  end

  assign set_mask     = ~({SET_W{1'b1}} << iw_eff);
  assign push_req.set = in_tdata[OFF_W +: SET_W] & set_mask;
  assign push_req.tag = in_tdata[ADDR_W-1:OFF_W] >> iw_eff;

  assign in_tready = !q_full && !clearing;
  assign push      = in_tvalid && in_tready;

endmodule
`default_nettype wire

// ===== src/sacrr_queue.sv =====
`default_nettype none
module sacrr_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  sacrr_pkg::req_t     push_req,
  output logic                full,
  input  wire                 pop,
  output logic                head_valid,
  output sacrr_pkg::req_t     head_req
);
  import sacrr_pkg::*;

  req_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_req   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

endmodule
`default_nettype wire

// ===== src/sacrr_back.sv =====
`default_nettype none
module sacrr_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire [sacrr_pkg::NW_W-1:0]   ways_eff,
  input  wire                         q_valid,
  input  sacrr_pkg::req_t             q_req,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output sacrr_pkg::result_t          out_res
);
  import sacrr_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  req_t             look_req_r;

  // per set: {round-robin pointer, valid bit per way}
  logic [META_W-1:0] meta_mem [SETS];
  logic [META_W-1:0] meta_rd_r;
  logic [TAG_W-1:0]  tag_rd_r [WAYS];

  logic              meta_re, meta_we;
  logic [SET_W-1:0]  meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [WAYS-1:0]   tag_we;

  logic [WAYS-1:0]  valid_row, hit_vec, free_vec, valid_new;
  logic [WAY_W-1:0] ptr, ptr_new, way_sel, hit_way, free_way;
  logic [NW_W-1:0]  victim, victim_inc;
  logic             is_hit, is_fill, resolve;

  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;

  assign clearing = (state_r == ST_CLEAR);
  assign meta_re  = (state_r == ST_IDLE) && q_valid;
  assign q_pop    = meta_re;
  assign resolve  = (state_r == ST_LOOK) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (resolve) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_re) begin
      look_req_r <= q_req;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rd_r <= meta_mem[q_req.set];
    end
  end

  for (genvar g = 0; g < WAYS; g++) begin : g_way
    logic [TAG_W-1:0] tag_mem [SETS];

    always_ff @(posedge clk) begin
      if (tag_we[g]) begin
        tag_mem[look_req_r.set] <= look_req_r.tag;
      end
      if (meta_re) begin
        tag_rd_r[g] <= tag_mem[q_req.set];
      end
    end
  end

  assign valid_row = meta_rd_r[WAYS-1:0];
  assign ptr       = meta_rd_r[META_W-1:WAYS];

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = (NW_W'(w) < ways_eff) && valid_row[w] &&
                    (tag_rd_r[w] == look_req_r.tag);
      free_vec[w] = (NW_W'(w) < ways_eff) && !valid_row[w];
    end
    // scan downward so the lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // stored pointer may exceed the ways now in use: reduce it
  always_comb begin
    victim = NW_W'(ptr);
    for (int i = 0; i < WAYS; i++) begin
      if (victim >= ways_eff) begin
        victim = victim - ways_eff;
      end
    end
    victim_inc = victim + 1'b1;
    if (victim_inc == ways_eff) begin
      victim_inc = '0;
    end
  end

  always_comb begin
    is_hit    = |hit_vec;
    is_fill   = !is_hit && (|free_vec);
    way_sel   = is_hit ? hit_way : (is_fill ? free_way : victim[WAY_W-1:0]);
    ptr_new   = (is_hit || is_fill) ? ptr : victim_inc[WAY_W-1:0];
    valid_new = valid_row | (WAYS'(1) << way_sel);
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = look_req_r.set;
    meta_wdata = {ptr_new, valid_new};
    tag_we     = '0;
    if (state_r == ST_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_cnt_r;
      meta_wdata = '0;
    end else if (resolve && !is_hit) begin
      meta_we = 1'b1;
      tag_we  = WAYS'(1) << way_sel;
    end
  end

  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (resolve) begin
      out_valid_nxt = 1'b1;
      if (is_hit) begin
        if (hit_cnt_r != '1) begin
          hit_cnt_nxt = hit_cnt_r + 1'b1;
        end
      end else if (miss_cnt_r != '1) begin
        miss_cnt_nxt = miss_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve) begin
      out_res_r.is_hit       <= is_hit;
      out_res_r.filled_empty <= is_fill;
      out_res_r.way_used     <= way_sel;
      out_res_r.hit_total    <= hit_cnt_nxt;
      out_res_r.miss_total   <= miss_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

endmodule
`default_nettype wire

// ===== src/set_assoc_cache_round_robin.sv =====
// Flow: an accepted address item is queued, then its set's tag and per-set
// state memories are read and the result is registered. The lookup finishes
// each item, writing those memories back on a miss, before it pops the next.
// Reset: synchronous, active low; a pass then clears the valid bits and
// round-robin pointers of all 256 sets, with in_tready held low until it ends.
`default_nettype none
module set_assoc_cache_round_robin (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [sacrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [sacrr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [31:0] address
  input  wire [sacrr_pkg::ADDR_W-1:0]         in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [0] is_hit, [1] filled_empty, [3:2] way_used, [35:4] hit_total,
  // [67:36] miss_total, [71:68] zero
  output logic [sacrr_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import sacrr_pkg::*;

  logic            push, q_full, q_valid, q_pop, clearing;
  req_t            push_req, q_req;
  logic [NW_W-1:0] ways_eff;
  result_t         out_res;

  sacrr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .push_req  (push_req),
    .ways_eff  (ways_eff)
  );

  sacrr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_req   (q_req)
  );

  sacrr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ways_eff   (ways_eff),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_res};

endmodule
`default_nettype wire
